>>> design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared constants, types and arithmetic helpers for the haversine core.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int unsigned LatW    = 31;
  localparam int unsigned LonW    = 32;
  localparam int unsigned RadiusW = 23;
  localparam int unsigned DistW   = 31;

  // pi * 2^62 and derived degree-to-radian factor (degrees * 10^7 units)
  localparam logic [63:0] PiQ62   = 64'hC90FDAA22168C235;
  localparam logic [63:0] D2rQ62  = (PiQ62 + 64'd900000000) / 64'd1800000000;
  localparam logic [63:0] GainQ40 = 64'd667681663043;

  localparam logic signed [35:0] Deg7Half    = 36'sd1800000000;
  localparam logic signed [35:0] Deg7Quarter = 36'sd900000000;
  localparam logic signed [35:0] Deg7Full    = 36'sd3600000000;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Working word of the datapath: wide enough for QF values with F up to 40.
  localparam int unsigned WordW = 48;
  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    logic signed [LatW-1:0] lat_a;
    logic signed [LonW-1:0] lon_a;
    logic signed [LatW-1:0] lat_b;
    logic signed [LonW-1:0] lon_b;
  } pos_pair_t;

  // atan(2^-i) at scale 2^62, rounded to frac bits
  function automatic word_t atan_entry(input int unsigned i, input int unsigned frac);
    logic signed [65:0] t;
    logic [65:0]        term;
    logic               minus;
    logic [65:0]        r;
    int unsigned        sh;
    t = '0;
    minus = 1'b0;
    if (i == 0) begin
      t = {2'b00, PiQ62 >> 2};
    end else begin
      for (int unsigned k = 1; k < 64; k += 2) begin
        if (i * k <= 62) begin
          term = ((66'd1 << (62 - i * k)) + 66'(k / 2)) / 66'(k);
          t = minus ? t - $signed(term) : t + $signed(term);
          minus = !minus;
        end
      end
    end
    sh = 62 - frac;
    r = (66'(t) + (66'd1 << (sh - 1))) >> sh;
    return word_t'(r);
  endfunction

  // Arithmetic shift, floor rounding (native >>> already floors).
  function automatic word_t asr_w(input word_t v, input int unsigned s);
    return v >>> s;
  endfunction

endpackage

>>> design/gcd_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type T with a source and a sink modport.
// ----------------------------------------------------------------------------
interface gcd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/gcd_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation stage; rotation or vectoring mode, registered output.
// ----------------------------------------------------------------------------
module gcd_cell #(
  parameter int unsigned Shift = 0,
  parameter int unsigned Frac  = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           vector_i,
  input  gcd_pkg::word_t x_i,
  input  gcd_pkg::word_t y_i,
  input  gcd_pkg::word_t z_i,
  output gcd_pkg::word_t x_o,
  output gcd_pkg::word_t y_o,
  output gcd_pkg::word_t z_o
);
  import gcd_pkg::*;

  localparam word_t Atan = atan_entry(Shift, Frac);

  word_t dx, dy, x_d, y_d, z_d, x_q, y_q, z_q;
  logic  pos;

  always_comb begin
    dx  = asr_w(y_i, Shift);
    dy  = asr_w(x_i, Shift);
    pos = vector_i ? !y_i[WordW-1] : !z_i[WordW-1];
    // vectoring with y>=0 mirrors rotation with z<0
    if (pos ^ vector_i) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
    end
    z_d = pos ? (vector_i ? z_i + Atan : z_i - Atan)
              : (vector_i ? z_i - Atan : z_i + Atan);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

>>> design/gcd_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC chain
// Row of Stages cells; carries a TagW-bit side tag alongside the vectors.
// ----------------------------------------------------------------------------
module gcd_cordic #(
  parameter int unsigned Stages = 32,
  parameter int unsigned Frac   = 30,
  parameter int unsigned TagW   = 1
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            vector_i,
  input  gcd_pkg::word_t  x_i,
  input  gcd_pkg::word_t  y_i,
  input  gcd_pkg::word_t  z_i,
  input  logic [TagW-1:0] tag_i,
  output gcd_pkg::word_t  x_o,
  output gcd_pkg::word_t  y_o,
  output gcd_pkg::word_t  z_o,
  output logic [TagW-1:0] tag_o
);
  import gcd_pkg::*;

  word_t           xs [Stages+1];
  word_t           ys [Stages+1];
  word_t           zs [Stages+1];
  logic [TagW-1:0] tg_q [Stages];

  assign xs[0] = x_i;
  assign ys[0] = y_i;
  assign zs[0] = z_i;

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    gcd_cell #(.Shift(g), .Frac(Frac)) u_cell (
      .clk_i, .en_i, .vector_i,
      .x_i(xs[g]), .y_i(ys[g]), .z_i(zs[g]),
      .x_o(xs[g+1]), .y_o(ys[g+1]), .z_o(zs[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg_q[g] <= (g == 0) ? tag_i : tg_q[(g == 0) ? 0 : g-1];
      end
    end
  end

  assign x_o   = xs[Stages];
  assign y_o   = ys[Stages];
  assign z_o   = zs[Stages];
  assign tag_o = tg_q[Stages-1];
endmodule

>>> design/gcd_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// floor(sqrt(v * 2^Frac)), one result bit per cell, restoring form.
// ----------------------------------------------------------------------------
module gcd_sqrt #(
  parameter int unsigned Frac = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  gcd_pkg::word_t v_i,
  output gcd_pkg::word_t r_o
);
  import gcd_pkg::*;

  localparam int unsigned Bits = Frac + 1;
  localparam int unsigned RadW = 2 * Frac + 2;

  logic [RadW-1:0] rad_s [Bits+1];
  logic [Bits-1:0] res_s [Bits+1];
  logic [RadW-1:0] sq_s  [Bits+1];

  assign rad_s[0] = RadW'(v_i[Frac:0]) << Frac;
  assign res_s[0] = '0;
  assign sq_s[0]  = '0;

  for (genvar b = 0; b < Bits; b++) begin : g_bit
    localparam int unsigned Pos = Bits - 1 - b;
    logic [Bits-1:0] t, res_q;
    logic [RadW-1:0] cand, rad_q, sq_q;
    // square of the trial value built from the running square by adds only
    assign t    = res_s[b] | (Bits'(1) << Pos);
    assign cand = sq_s[b] + (RadW'(res_s[b]) << (Pos + 1)) + (RadW'(1) << (2 * Pos));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q <= rad_s[b];
        if (cand <= rad_s[b]) begin
          res_q <= t;
          sq_q  <= cand;
        end else begin
          res_q <= res_s[b];
          sq_q  <= sq_s[b];
        end
      end
    end
    assign rad_s[b+1] = rad_q;
    assign res_s[b+1] = res_q;
    assign sq_s[b+1]  = sq_q;
  end

  assign r_o = word_t'(res_s[Bits]);
endmodule

>>> design/great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// Great-circle distance core
// Haversine distance between two positions, pipelined CORDIC chains.
// ----------------------------------------------------------------------------
// The path from accepted input transaction to result is set by the two CORDIC
//   chains and the root chain, which lie in series.
// Throughput: one transaction per cycle; the whole pipe stalls only when the
//   output register is full and not taken.
// Reset: valid flags clear, radius_q returns to 6371000.
module great_circle_distance_core #(
  parameter int unsigned CORDIC_STAGES   = 32,
  parameter int unsigned ANGLE_FRAC_BITS = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  gcd_stream_if.sink   in_i,
  gcd_stream_if.sink   cfg_i,
  gcd_stream_if.source out_o
);
  import gcd_pkg::*;

  localparam int unsigned F     = ANGLE_FRAC_BITS;
  localparam int unsigned Lat   = 2 * CORDIC_STAGES + F + 9;
  localparam word_t       One   = word_t'(1) <<< F;
  localparam word_t       Gain  = word_t'((GainQ40 + (64'd1 << (39 - F))) >> (40 - F));

  // Pipeline advances whenever the output slot is free or being drained.
  logic en;
  logic [Lat-2:0] vld_q;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  logic [RadiusW-1:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(6371000);
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-3:0], in_i.valid};
    end
  end

  // ---- stage 1: angle wrap and fold -------------------------------------
  function automatic logic signed [35:0] wrap(input logic signed [35:0] v);
    logic signed [35:0] m;
    m = v;
    if (m >= Deg7Half) m = m - Deg7Full;
    else if (m < -Deg7Half) m = m + Deg7Full;
    if (m >= Deg7Half) m = m - Deg7Full;
    else if (m < -Deg7Half) m = m + Deg7Full;
    return m;
  endfunction

  // degrees*1e7 (|v| < 2^31) to radians QF, divided by 2^ex
  function automatic word_t to_rad(input logic signed [35:0] v, input int unsigned ex);
    logic [31:0]  mag;
    logic [95:0]  p;
    int unsigned  sh;
    logic [95:0]  r;
    mag = v[35] ? 32'(-v) : 32'(v);
    p   = 96'(mag) * 96'(D2rQ62);
    sh  = 62 - F + ex;
    r   = (p + (96'd1 << (sh - 1))) >> sh;
    return v[35] ? -word_t'(r) : word_t'(r);
  endfunction

  pos_pair_t pp;
  assign pp = in_i.data;

  logic signed [35:0] dlat_q, dlon_q, la_q, lb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q <= wrap(36'(pp.lat_b) - 36'(pp.lat_a));
      dlon_q <= wrap(36'(pp.lon_b) - 36'(pp.lon_a));
      la_q   <= wrap(36'(pp.lat_a));
      lb_q   <= wrap(36'(pp.lat_b));
    end
  end

  logic signed [35:0] fa, fb;
  logic               na, nb;
  always_comb begin
    fa = la_q; na = 1'b0;
    if (la_q > Deg7Quarter) begin fa = la_q - Deg7Half; na = 1'b1; end
    else if (la_q < -Deg7Quarter) begin fa = la_q + Deg7Half; na = 1'b1; end
    fb = lb_q; nb = 1'b0;
    if (lb_q > Deg7Quarter) begin fb = lb_q - Deg7Half; nb = 1'b1; end
    else if (lb_q < -Deg7Quarter) begin fb = lb_q + Deg7Half; nb = 1'b1; end
  end

  // ---- stage 2: radians (one multiplier row per angle) --------------------
  word_t zs1_q, zs2_q, zc1_q, zc2_q;
  logic  n1_q, n2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      zs1_q <= to_rad(dlat_q, 1);
      zs2_q <= to_rad(dlon_q, 1);
      zc1_q <= to_rad(fa, 0);
      zc2_q <= to_rad(fb, 0);
      n1_q  <= na;
      n2_q  <= nb;
    end
  end

  // ---- rotation chains: sin and cos -------------------------------------
  word_t s1x, s1y, s1z, s2x, s2y, s2z, c1x, c1y, c1z, c2x, c2y, c2z;
  logic  n1d, n2d, t0, t1;

  gcd_cordic #(.Stages(CORDIC_STAGES), .Frac(F)) u_s1 (
    .clk_i, .en_i(en), .vector_i(1'b0), .x_i(Gain), .y_i('0), .z_i(zs1_q),
    .tag_i(1'b0), .x_o(s1x), .y_o(s1y), .z_o(s1z), .tag_o(t0));
  gcd_cordic #(.Stages(CORDIC_STAGES), .Frac(F)) u_s2 (
    .clk_i, .en_i(en), .vector_i(1'b0), .x_i(Gain), .y_i('0), .z_i(zs2_q),
    .tag_i(1'b0), .x_o(s2x), .y_o(s2y), .z_o(s2z), .tag_o(t1));
  gcd_cordic #(.Stages(CORDIC_STAGES), .Frac(F)) u_c1 (
    .clk_i, .en_i(en), .vector_i(1'b0), .x_i(Gain), .y_i('0), .z_i(zc1_q),
    .tag_i(n1_q), .x_o(c1x), .y_o(c1y), .z_o(c1z), .tag_o(n1d));
  gcd_cordic #(.Stages(CORDIC_STAGES), .Frac(F)) u_c2 (
    .clk_i, .en_i(en), .vector_i(1'b0), .x_i(Gain), .y_i('0), .z_i(zc2_q),
    .tag_i(n2_q), .x_o(c2x), .y_o(c2y), .z_o(c2z), .tag_o(n2d));

  // round(a*b/2^F), ties away from zero; operands stay below 2^(F+2)
  function automatic word_t mulq(input word_t a, input word_t b);
    logic [F+1:0]   ma, mb;
    logic [2*F+3:0] p;
    logic           ng;
    ma = (F+2)'(a[WordW-1] ? -a : a);
    mb = (F+2)'(b[WordW-1] ? -b : b);
    ng = a[WordW-1] ^ b[WordW-1];
    p  = ((2*F+4)'(ma) * (2*F+4)'(mb) + ((2*F+4)'(1) << (F - 1))) >> F;
    return ng ? -word_t'(p) : word_t'(p);
  endfunction

  // ---- haversine products, each behind its own register ---------------------
  word_t c1_v, c2_v, p_ss1_q, p_ss2_q, p_cc_q, p_ss1b_q, a_q, p_t_q;
  assign c1_v = n1d ? -c1x : c1x;
  assign c2_v = n2d ? -c2x : c2x;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ss1_q  <= mulq(s1y, s1y);
      p_ss2_q  <= mulq(s2y, s2y);
      p_cc_q   <= mulq(c1_v, c2_v);
      p_ss1b_q <= p_ss1_q;
      p_t_q    <= mulq(p_cc_q, p_ss2_q);
      if ((p_ss1b_q + p_t_q) < 0) a_q <= '0;
      else if ((p_ss1b_q + p_t_q) > One) a_q <= One;
      else a_q <= p_ss1b_q + p_t_q;
    end
  end

  // ---- roots and vectoring chain ------------------------------------------
  word_t ra, rb;
  gcd_sqrt #(.Frac(F)) u_sq_a (.clk_i, .en_i(en), .v_i(a_q), .r_o(ra));
  gcd_sqrt #(.Frac(F)) u_sq_b (.clk_i, .en_i(en), .v_i(One - a_q), .r_o(rb));

  word_t vx, vy, vz;
  logic  t2;
  gcd_cordic #(.Stages(CORDIC_STAGES), .Frac(F)) u_at (
    .clk_i, .en_i(en), .vector_i(1'b1), .x_i(rb), .y_i(ra), .z_i('0),
    .tag_i(1'b0), .x_o(vx), .y_o(vy), .z_o(vz), .tag_o(t2));

  // ---- scale by radius (registered in c_q, then d_q) and output register ---
  word_t c_q;
  logic [RadiusW+6:0] rad100_q;
  logic [2*WordW-1:0] d_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q      <= vz[WordW-1] ? '0 : (vz <<< 1);
      rad100_q <= (RadiusW+7)'(radius_q) * (RadiusW+7)'(100);
      d_q      <= ((2*WordW)'(c_q) * (2*WordW)'(rad100_q) + ((2*WordW)'(1) << (F - 1))) >> F;
    end
  end

  logic [DistW-1:0] dist_q;
  logic             ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vld_q[Lat-2];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (d_q > (2*WordW)'(DistMax)) ? DistMax : DistW'(d_q);
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = dist_q;

  // spare outputs and side tags of the chains carry nothing
  logic unused;
  assign unused = ^{s1x, s1z, s2x, s2z, c1y, c1z, c2y, c2z, vx, vy, t0, t1, t2};

  // ---- checks ---------------------------------------------------------------
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe advanced during stall");
  a_acl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[Lat-2] |=> out_o.valid)
    else $error("result lost at output");
endmodule
